### hdl/yuyv_to_bgr_framebuffer_writer_unit_defines.svh
// Assertion macros for the framebuffer writer
`ifndef YUYV_TO_BGR_FRAMEBUFFER_WRITER_UNIT_DEFINES_SVH
`define YUYV_TO_BGR_FRAMEBUFFER_WRITER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define YBFW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define YBFW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define YBFW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define YBFW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/ybfw_pkg.sv
package ybfw_pkg;

    localparam int unsigned CfgDataW = 14;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned AddrW    = 28;
    localparam int unsigned PxW      = 13;
    localparam int unsigned PyW      = 14;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_X_OFFSET    = 3'd2,
        CFG_Y_OFFSET    = 3'd3,
        CFG_BPP         = 3'd4,
        CFG_LINE_STRIDE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] src_width;
        logic [11:0] src_height;
        logic [11:0] x_offset;
        logic [12:0] y_offset;
        logic [2:0]  bytes_per_pixel;
        logic [13:0] line_stride;
    } t_cfg;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] luma0;
        logic [7:0] chroma_u;
        logic [7:0] luma1;
        logic [7:0] chroma_v;
    } t_in_item;

    typedef struct packed {
        logic [AddrW-1:0] pixel0_addr;
        logic [AddrW-1:0] pixel1_addr;
        logic [7:0]       blue0;
        logic [7:0]       green0;
        logic [7:0]       red0;
        logic [7:0]       blue1;
        logic [7:0]       green1;
        logic [7:0]       red1;
    } t_out_item;

    typedef struct packed {
        logic           visible;
        logic [PxW-1:0] px;
        logic [PyW-1:0] py;
    } t_pos_info;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_bgr;

endpackage

### hdl/ybfw_pos.sv
module ybfw_pos #(
    parameter int unsigned MAX_W = 800,
    parameter int unsigned MAX_H = 480
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ybfw_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  logic                 i_frame_start,
    output ybfw_pkg::t_pos_info  o_info
);
    import ybfw_pkg::*;

    localparam logic [11:0] MaxW   = 12'(MAX_W);
    localparam logic [11:0] MaxH   = 12'(MAX_H);
    localparam logic [11:0] RowMax = 12'hFFF;

    logic [10:0] r_col, n_col;
    logic [11:0] r_row, n_row;
    logic [10:0] w_col;
    logic [11:0] w_row;
    logic [11:0] w_vis_w, w_vis_h;
    logic [12:0] w_vis_pairs, w_ppl, w_col_inc;

    always_comb begin
        w_col       = i_frame_start ? 11'd0 : r_col;
        w_row       = i_frame_start ? 12'd0 : r_row;
        w_vis_w     = (i_cfg.src_width > MaxW) ? MaxW : i_cfg.src_width;
        w_vis_h     = (i_cfg.src_height > MaxH) ? MaxH : i_cfg.src_height;
        w_vis_pairs = ({1'b0, w_vis_w} + 13'd1) >> 1;
        w_ppl       = ({1'b0, i_cfg.src_width} + 13'd1) >> 1;
        w_col_inc   = {2'b00, w_col} + 13'd1;

        o_info.visible = (w_row < w_vis_h) && ({2'b00, w_col} < w_vis_pairs);
        o_info.px      = {1'b0, w_col, 1'b0} + {1'b0, i_cfg.x_offset};
        o_info.py      = {2'b00, w_row} + {1'b0, i_cfg.y_offset};

        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (w_col_inc >= w_ppl) begin
                n_col = 11'd0;
                n_row = (w_row < RowMax) ? w_row + 12'd1 : w_row;
            end else begin
                n_col = w_col_inc[10:0];
                n_row = w_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

### hdl/ybfw_lane.sv
module ybfw_lane (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [7:0]        i_luma,
    input  logic [7:0]        i_chroma_u,
    input  logic [7:0]        i_chroma_v,
    output ybfw_pkg::t_bgr    o_bgr
);
    import ybfw_pkg::*;

    localparam int unsigned SumW = 19;
    localparam logic signed [SumW-1:0] CoefY  = 19'sd298;
    localparam logic signed [SumW-1:0] CoefRv = 19'sd409;
    localparam logic signed [SumW-1:0] CoefGu = 19'sd100;
    localparam logic signed [SumW-1:0] CoefGv = 19'sd208;
    localparam logic signed [SumW-1:0] CoefBu = 19'sd516;
    localparam logic signed [SumW-1:0] Round  = 19'sd128;
    localparam logic signed [8:0]      ChromaBias = 9'sd128;

    logic signed [8:0]      w_u9, w_v9;
    logic signed [SumW-1:0] w_y, w_u, w_v;
    logic signed [SumW-1:0] r_sum_b, r_sum_g, r_sum_r;

    function automatic logic [7:0] clamp8(input logic signed [SumW-1:0] t);
        logic [7:0] q;
        if (t[SumW-1]) begin
            q = 8'd0;
        end else if (|t[SumW-2:16]) begin
            q = 8'hFF;
        end else begin
            q = t[15:8];
        end
        return q;
    endfunction

    always_comb begin
        w_u9 = $signed({1'b0, i_chroma_u}) - ChromaBias;
        w_v9 = $signed({1'b0, i_chroma_v}) - ChromaBias;
        w_y  = $signed({11'd0, i_luma});
        w_u  = SumW'(w_u9);
        w_v  = SumW'(w_v9);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_b <= CoefY * w_y + CoefBu * w_u + Round;
            r_sum_g <= CoefY * w_y - CoefGu * w_u - CoefGv * w_v + Round;
            r_sum_r <= CoefY * w_y + CoefRv * w_v + Round;
        end
    end

    always_comb begin
        o_bgr.blue  = clamp8(r_sum_b);
        o_bgr.green = clamp8(r_sum_g);
        o_bgr.red   = clamp8(r_sum_r);
    end

endmodule

### hdl/ybfw_merge.sv
module ybfw_merge (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ybfw_pkg::PxW-1:0]    i_px,
    input  logic [ybfw_pkg::PyW-1:0]    i_py,
    input  ybfw_pkg::t_cfg              i_cfg,
    input  ybfw_pkg::t_bgr              i_bgr0,
    input  ybfw_pkg::t_bgr              i_bgr1,
    output ybfw_pkg::t_out_item         o_item
);
    import ybfw_pkg::*;

    logic [15:0]      r_ax;
    logic [AddrW-1:0] r_ay;
    logic [AddrW-1:0] w_a0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax <= 16'(i_px) * 16'(i_cfg.bytes_per_pixel);
            r_ay <= AddrW'(i_py) * AddrW'(i_cfg.line_stride);
        end
    end

    always_comb begin
        w_a0               = AddrW'(r_ax) + r_ay;
        o_item.pixel0_addr = w_a0;
        o_item.pixel1_addr = w_a0 + AddrW'(i_cfg.bytes_per_pixel);
        o_item.blue0       = i_bgr0.blue;
        o_item.green0      = i_bgr0.green;
        o_item.red0        = i_bgr0.red;
        o_item.blue1       = i_bgr1.blue;
        o_item.green1      = i_bgr1.green;
        o_item.red1        = i_bgr1.red;
    end

endmodule

### hdl/yuyv_to_bgr_framebuffer_writer_unit.sv
// A visible request is registered in stages A, B and C in turn, and stage C drives o_valid.
// Throughput: one request per cycle; the three stages stall only on output backpressure.
// Requests outside the visible window update the position and leave no result.
// Reset (synchronous, active low) empties the pipeline, zeroes column and row,
// and loads the configuration registers with their defaults.
`include "yuyv_to_bgr_framebuffer_writer_unit_defines.svh"

module yuyv_to_bgr_framebuffer_writer_unit #(
    parameter int unsigned MAX_W = 800,
    parameter int unsigned MAX_H = 480
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ybfw_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [ybfw_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  ybfw_pkg::t_in_item                i_item,
    output logic                              o_valid,
    input  logic                              i_ready,
    output ybfw_pkg::t_out_item               o_item
);
    import ybfw_pkg::*;

    t_cfg      r_cfg, n_cfg;
    t_pos_info w_pos;
    logic      w_accept;
    logic      w_rdy_a, w_rdy_b, w_rdy_c;

    logic           r_a_valid, r_b_valid, r_c_valid;
    t_in_item       r_a_item;
    logic [PxW-1:0] r_a_px;
    logic [PyW-1:0] r_a_py;
    t_bgr           w_bgr0, w_bgr1;
    t_out_item      w_merged;
    t_out_item      r_out;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:   n_cfg.src_width       = i_cfg_data[11:0];
                CFG_SRC_HEIGHT:  n_cfg.src_height      = i_cfg_data[11:0];
                CFG_X_OFFSET:    n_cfg.x_offset        = i_cfg_data[11:0];
                CFG_Y_OFFSET:    n_cfg.y_offset        = i_cfg_data[12:0];
                CFG_BPP:         n_cfg.bytes_per_pixel = i_cfg_data[2:0];
                CFG_LINE_STRIDE: n_cfg.line_stride     = i_cfg_data[13:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width       <= 12'd640;
            r_cfg.src_height      <= 12'd480;
            r_cfg.x_offset        <= 12'd0;
            r_cfg.y_offset        <= 13'd0;
            r_cfg.bytes_per_pixel <= 3'd3;
            r_cfg.line_stride     <= 14'd2400;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Advance each stage when the one downstream has room
    assign w_rdy_c  = !r_c_valid || i_ready;
    assign w_rdy_b  = !r_b_valid || w_rdy_c;
    assign w_rdy_a  = !r_a_valid || w_rdy_b;
    assign o_ready  = w_rdy_a;
    assign w_accept = i_valid && w_rdy_a;

    ybfw_pos #(
        .MAX_W(MAX_W),
        .MAX_H(MAX_H)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_frame_start(i_item.frame_start),
        .o_info       (w_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_valid <= i_valid && w_pos.visible;
            end
            if (w_rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_rdy_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_item <= i_item;
            r_a_px   <= w_pos.px;
            r_a_py   <= w_pos.py;
        end
        if (w_rdy_c) begin
            r_out <= w_merged;
        end
    end

    ybfw_lane u_lane0 (
        .i_clk     (i_clk),
        .i_en      (w_rdy_b),
        .i_luma    (r_a_item.luma0),
        .i_chroma_u(r_a_item.chroma_u),
        .i_chroma_v(r_a_item.chroma_v),
        .o_bgr     (w_bgr0)
    );

    ybfw_lane u_lane1 (
        .i_clk     (i_clk),
        .i_en      (w_rdy_b),
        .i_luma    (r_a_item.luma1),
        .i_chroma_u(r_a_item.chroma_u),
        .i_chroma_v(r_a_item.chroma_v),
        .o_bgr     (w_bgr1)
    );

    ybfw_merge u_merge (
        .i_clk (i_clk),
        .i_en  (w_rdy_b),
        .i_px  (r_a_px),
        .i_py  (r_a_py),
        .i_cfg (r_cfg),
        .i_bgr0(w_bgr0),
        .i_bgr1(w_bgr1),
        .o_item(w_merged)
    );

    assign o_valid = r_c_valid;
    assign o_item  = r_out;

    `YBFW_ASSERT_NXT(a_visible_enters, i_clk, i_rst_n, w_accept && w_pos.visible, r_a_valid, "visible request lost at entry")
    `YBFW_ASSERT_NXT(a_stage_b_holds, i_clk, i_rst_n, r_b_valid && !w_rdy_c, r_b_valid, "stalled request dropped in stage B")
    `YBFW_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !r_a_valid, o_ready, "entry stage empty but not ready")

endmodule
